// ===== hw/rtl/sqvs_pkg.sv =====
// sqvs_pkg: shared constants, types and sine/cosine rom contents for the
// sprite quad vertex setup block. No dependencies.
package sqvs_pkg;

  localparam int SINE_TABLE_ENTRIES = 1024;
  localparam int SINE_IDX_W         = $clog2(SINE_TABLE_ENTRIES);
  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

  localparam int REG_W = 14;
  localparam logic [REG_W-1:0] VIEWPORT_W_RST = 14'd1280;
  localparam logic [REG_W-1:0] VIEWPORT_H_RST = 14'd720;
  localparam logic [REG_W-1:0] TEXTURE_W_RST  = 14'd256;
  localparam logic [REG_W-1:0] TEXTURE_H_RST  = 14'd256;

  // configuration register indexes
  localparam logic [7:0] REG_VIEWPORT_W = 8'd0;
  localparam logic [7:0] REG_VIEWPORT_H = 8'd1;
  localparam logic [7:0] REG_TEXTURE_W  = 8'd2;
  localparam logic [7:0] REG_TEXTURE_H  = 8'd3;

  localparam int IN_DATA_W  = 208;
  localparam int OUT_DATA_W = 104;

  // divider: 40-bit biased numerator, 19-bit divisor, 18 quotient bits
  localparam int DIV_N_W = 40;
  localparam int DIV_D_W = 19;
  localparam int DIV_Q_W = 18;
  localparam int DIV_R_W = DIV_D_W + DIV_Q_W;
  localparam int DIV_LAT = DIV_Q_W + 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] LAST_VTX = 3'd5;

  typedef logic signed [15:0] trig_t;
  typedef trig_t sine_rom_t [SINE_TABLE_ENTRIES];

  // size registers with zero already mapped to one
  typedef struct packed {
    logic [REG_W-1:0] vp_w;
    logic [REG_W-1:0] vp_h;
    logic [REG_W-1:0] tex_w;
    logic [REG_W-1:0] tex_h;
  } cfg_t;

  typedef struct packed {
    logic signed [21:0] cx5;
    logic signed [21:0] cy5;
    logic signed [19:0] dw;
    logic signed [19:0] dh;
    trig_t              cos_v;
    trig_t              sin_v;
    logic [31:0]        color;
    logic signed [20:0] u0;
    logic signed [20:0] u1;
    logic signed [20:0] v0;
    logic signed [20:0] v1;
  } cmd_t;

  function automatic trig_t sin_of_phase(input logic [31:0] ph);
    logic [63:0]        r;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic signed [63:0] q;
    r = {34'd0, ph[29:0]};
    if (ph[30]) r = 64'h4000_0000 - r;
    x = (r * PI_HALF_Q30) >> 30;
    x2 = (x * x) >> 30;
    term = x;
    sum = $signed(x);
    for (int k = 1; k <= 8; k++) begin
      term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
      if (k[0]) sum = sum - $signed(term);
      else sum = sum + $signed(term);
    end
    if (sum < 0) sum = 0;
    q = (sum + 64'sd32768) >>> 16;
    if (q > 64'sd16384) q = 64'sd16384;
    return ph[31] ? 16'(-q) : 16'(q);
  endfunction

  function automatic sine_rom_t build_rom(input logic cosine);
    sine_rom_t   rom;
    logic [31:0] ph;
    for (int i = 0; i < SINE_TABLE_ENTRIES; i++) begin
      ph = 32'((64'(i) << 32) / SINE_TABLE_ENTRIES);
      rom[i] = sin_of_phase(cosine ? ph + 32'h4000_0000 : ph);
    end
    return rom;
  endfunction

  localparam sine_rom_t SIN_ROM = build_rom(1'b0);
  localparam sine_rom_t COS_ROM = build_rom(1'b1);

endpackage

// ===== hw/rtl/sprite_quad_vertex_setup.sv =====
// Sprite quad vertex setup: one rotated sprite command in, six ndc vertices out.
// Sustained rate is one vertex per cycle while the output accepts, set by the
// back part issuing one vertex a cycle into its arithmetic pipeline; the front
// takes new commands while the back still works on one. A vertex passes stages
// a to c, the dividers and the output register. Size registers are written over
// the cfg port, which is always ready; a register holding zero acts as one.
// Depends on sqvs_pkg, sqvs_front, sqvs_queue, sqvs_back and sqvs_div.
module sprite_quad_vertex_setup (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // dest_x, dest_y, dest_w, dest_h, angle_turn, color_rgba,
  // src_x, src_y, src_w, src_h
  input  logic [sqvs_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                            s_axis_tuser, // whole_texture
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // vertex_x, vertex_y, vertex_color, tex_u, tex_v, zero pad
  output logic [sqvs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                            m_axis_tlast, // last_vertex
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [7:0]                      cfg_index,
  input  logic [sqvs_pkg::REG_W-1:0]      cfg_data
);

  logic [sqvs_pkg::REG_W-1:0] vp_w, vp_h, tex_w, tex_h;
  sqvs_pkg::cfg_t cfg;
  logic           q_ready, q_push, q_valid, q_pop;
  sqvs_pkg::cmd_t q_data, q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp_w  <= sqvs_pkg::VIEWPORT_W_RST;
      vp_h  <= sqvs_pkg::VIEWPORT_H_RST;
      tex_w <= sqvs_pkg::TEXTURE_W_RST;
      tex_h <= sqvs_pkg::TEXTURE_H_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sqvs_pkg::REG_VIEWPORT_W: vp_w  <= cfg_data;
        sqvs_pkg::REG_VIEWPORT_H: vp_h  <= cfg_data;
        sqvs_pkg::REG_TEXTURE_W:  tex_w <= cfg_data;
        sqvs_pkg::REG_TEXTURE_H:  tex_h <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg.vp_w  = (vp_w == '0) ? sqvs_pkg::REG_W'(1) : vp_w;
  assign cfg.vp_h  = (vp_h == '0) ? sqvs_pkg::REG_W'(1) : vp_h;
  assign cfg.tex_w = (tex_w == '0) ? sqvs_pkg::REG_W'(1) : tex_w;
  assign cfg.tex_h = (tex_h == '0) ? sqvs_pkg::REG_W'(1) : tex_h;

  sqvs_front u_front (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .cfg(cfg), .q_ready(q_ready), .q_push(q_push), .q_data(q_data)
  );

  sqvs_queue u_queue (
    .clk(clk), .rst(rst),
    .push(q_push), .push_data(q_data), .ready(q_ready),
    .valid(q_valid), .pop(q_pop), .head(q_head)
  );

  sqvs_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg),
    .q_valid(q_valid), .q_head(q_head), .q_pop(q_pop),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

endmodule

// ===== hw/rtl/sqvs_div.sv =====
// sqvs_div: pipelined restoring divider, one quotient bit per stage,
// saturating to the quotient range. Depends on sqvs_pkg.
module sqvs_div (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [sqvs_pkg::DIV_N_W-1:0] num,
  input  logic [sqvs_pkg::DIV_D_W-1:0]        den,
  output logic [sqvs_pkg::DIV_Q_W-1:0]        quo
);

  logic [sqvs_pkg::DIV_R_W-1:0] rem   [sqvs_pkg::DIV_LAT];
  logic [sqvs_pkg::DIV_D_W-1:0] den_p [sqvs_pkg::DIV_LAT];
  logic [sqvs_pkg::DIV_Q_W-1:0] quo_p [sqvs_pkg::DIV_LAT];
  logic                         hi_p  [sqvs_pkg::DIV_LAT];
  logic                         lo_p  [sqvs_pkg::DIV_LAT];
  logic [sqvs_pkg::DIV_R_W-1:0] nrem  [sqvs_pkg::DIV_LAT];
  logic                         take  [sqvs_pkg::DIV_LAT];
  logic [sqvs_pkg::DIV_R_W:0]   dsh   [sqvs_pkg::DIV_LAT];
  logic [sqvs_pkg::DIV_R_W:0]   diff  [sqvs_pkg::DIV_LAT];
  logic signed [sqvs_pkg::DIV_N_W-1:0] den_top;
  logic over;

  // quotient would not fit: numerator at or above den * 2^Q
  assign den_top = $signed(sqvs_pkg::DIV_N_W'({den, sqvs_pkg::DIV_Q_W'(0)}));
  assign over    = !num[sqvs_pkg::DIV_N_W-1] && (num >= den_top);

  always_comb begin
    nrem[0] = '0;
    take[0] = 1'b0;
    dsh[0]  = '0;
    diff[0] = '0;
    for (int j = 1; j < sqvs_pkg::DIV_LAT; j++) begin
      dsh[j]  = (sqvs_pkg::DIV_R_W + 1)'(den_p[j-1]) << (sqvs_pkg::DIV_Q_W - j);
      diff[j] = {1'b0, rem[j-1]} - dsh[j];
      take[j] = !diff[j][sqvs_pkg::DIV_R_W];
      nrem[j] = take[j] ? diff[j][sqvs_pkg::DIV_R_W-1:0] : rem[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]   <= num[sqvs_pkg::DIV_R_W-1:0];
      den_p[0] <= den;
      quo_p[0] <= '0;
      hi_p[0]  <= over;
      lo_p[0]  <= num[sqvs_pkg::DIV_N_W-1];
      for (int j = 1; j < sqvs_pkg::DIV_LAT; j++) begin
        rem[j]   <= nrem[j];
        den_p[j] <= den_p[j-1];
        quo_p[j] <= {quo_p[j-1][sqvs_pkg::DIV_Q_W-2:0], take[j]};
        hi_p[j]  <= hi_p[j-1];
        lo_p[j]  <= lo_p[j-1];
      end
    end
  end

  assign quo = hi_p[sqvs_pkg::DIV_LAT-1] ? '1 :
               lo_p[sqvs_pkg::DIV_LAT-1] ? '0 : quo_p[sqvs_pkg::DIV_LAT-1];

endmodule

// ===== hw/rtl/sqvs_front.sv =====
// sqvs_front: accepts sprite commands, resolves the whole-texture case and
// reads sine/cosine from rom into one command register. Depends on sqvs_pkg.
module sqvs_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // dest_x, dest_y, dest_w, dest_h, angle_turn, color_rgba,
  // src_x, src_y, src_w, src_h
  input  logic [sqvs_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  input  logic                             s_axis_tuser, // whole_texture
  input  sqvs_pkg::cfg_t                   cfg,
  input  logic                             q_ready,
  output logic                             q_push,
  output sqvs_pkg::cmd_t                   q_data
);

  logic signed [19:0] dx, dy, dw, dh, sx, sy, sw, sh;
  logic [15:0]        ang;
  logic signed [20:0] sw_eff, sh_eff;
  logic [31:0]        prod;
  logic [sqvs_pkg::SINE_IDX_W-1:0] idx;
  sqvs_pkg::cmd_t     cmd_d;
  sqvs_pkg::cmd_t     cmd;
  logic               fv;
  logic               take;

  assign dx  = s_axis_tdata[19:0];
  assign dy  = s_axis_tdata[39:20];
  assign dw  = s_axis_tdata[59:40];
  assign dh  = s_axis_tdata[79:60];
  assign ang = s_axis_tdata[95:80];
  assign sx  = s_axis_tdata[147:128];
  assign sy  = s_axis_tdata[167:148];
  assign sw  = s_axis_tdata[187:168];
  assign sh  = s_axis_tdata[207:188];

  assign sw_eff = s_axis_tuser ? $signed({3'b000, cfg.tex_w, 4'b0000}) : 21'(sw);
  assign sh_eff = s_axis_tuser ? $signed({3'b000, cfg.tex_h, 4'b0000}) : 21'(sh);

  assign prod = 32'(ang) * 32'(sqvs_pkg::SINE_TABLE_ENTRIES);
  assign idx  = prod[16 +: sqvs_pkg::SINE_IDX_W];

  always_comb begin
    cmd_d.cx5   = (22'(dx) <<< 1) + 22'(dw);
    cmd_d.cy5   = (22'(dy) <<< 1) + 22'(dh);
    cmd_d.dw    = dw;
    cmd_d.dh    = dh;
    cmd_d.cos_v = sqvs_pkg::COS_ROM[idx];
    cmd_d.sin_v = sqvs_pkg::SIN_ROM[idx];
    cmd_d.color = s_axis_tdata[127:96];
    cmd_d.u0    = 21'(sx);
    cmd_d.u1    = 21'(sx) + sw_eff;
    cmd_d.v0    = 21'(sy);
    cmd_d.v1    = 21'(sy) + sh_eff;
  end

  assign s_axis_tready = !fv || q_ready;
  assign take          = s_axis_tvalid && s_axis_tready;
  assign q_push        = fv && q_ready;
  assign q_data        = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (take) begin
      fv <= 1'b1;
    end else if (q_push) begin
      fv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd <= cmd_d;
    end
  end

  // a held command must not be dropped while the queue is full
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (fv && !q_ready) |=> fv)
    else $error("front command lost while queue full");

endmodule

// ===== hw/rtl/sqvs_queue.sv =====
// sqvs_queue: short command queue between front and back parts.
// Depends on sqvs_pkg.
module sqvs_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  sqvs_pkg::cmd_t push_data,
  output logic           ready,
  output logic           valid,
  input  logic           pop,
  output sqvs_pkg::cmd_t head
);

  sqvs_pkg::cmd_t mem [sqvs_pkg::QUEUE_DEPTH];
  logic [sqvs_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [sqvs_pkg::QCNT_W-1:0] count;

  assign ready = count != sqvs_pkg::QCNT_W'(sqvs_pkg::QUEUE_DEPTH);
  assign valid = count != '0;
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == sqvs_pkg::QPTR_W'(sqvs_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == sqvs_pkg::QPTR_W'(sqvs_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  a_no_over: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != sqvs_pkg::QCNT_W'(sqvs_pkg::QUEUE_DEPTH)))
    else $error("push into full queue");

  a_no_under: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("pop from empty queue");

endmodule

// ===== hw/rtl/sqvs_back.sv =====
// sqvs_back: steps through the six vertices of the queued command, rotates,
// maps to ndc and texture space through pipelined dividers, drives the output
// register. Depends on sqvs_pkg and sqvs_div.
module sqvs_back (
  input  logic                            clk,
  input  logic                            rst,
  input  sqvs_pkg::cfg_t                  cfg,
  input  logic                            q_valid,
  input  sqvs_pkg::cmd_t                  q_head,
  output logic                            q_pop,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // vertex_x, vertex_y, vertex_color, tex_u, tex_v, zero pad
  output logic [sqvs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                            m_axis_tlast // last_vertex
);

  logic       adv, issue;
  logic [2:0] cnt;
  logic [1:0] corner;

  logic signed [20:0] rx, ry, su_d, sv_d;

  // stage a: products
  logic               a_v, a_last;
  logic signed [36:0] a_pcx, a_psy, a_psx, a_pcy;
  logic signed [21:0] a_cx5, a_cy5;
  logic signed [20:0] a_su, a_sv;
  logic [31:0]        a_col;
  // stage b: corner position
  logic               b_v, b_last;
  logic signed [38:0] b_x, b_y;
  logic signed [20:0] b_su, b_sv;
  logic [31:0]        b_col;
  // stage c: biased numerators
  logic               c_v, c_last;
  logic signed [sqvs_pkg::DIV_N_W-1:0] c_nx, c_ny, c_nu, c_nv;
  logic [31:0]        c_col;

  logic signed [sqvs_pkg::DIV_N_W-1:0] kx, ky, ku, kv;
  logic [sqvs_pkg::DIV_D_W-1:0] den_x, den_y, den_u, den_v;
  logic [sqvs_pkg::DIV_Q_W-1:0] qx, qy, qu, qv;

  logic        sb_v    [sqvs_pkg::DIV_LAT];
  logic        sb_last [sqvs_pkg::DIV_LAT];
  logic [31:0] sb_col  [sqvs_pkg::DIV_LAT];

  logic [15:0] x16, y16, vx, vy;

  assign adv   = !m_axis_tvalid || m_axis_tready;
  assign issue = q_valid && adv;
  assign q_pop = issue && (cnt == sqvs_pkg::LAST_VTX);

  // two triangles: corners 0 1 2, 2 1 3
  always_comb begin
    unique case (cnt)
      3'd0:    corner = 2'd0;
      3'd1:    corner = 2'd1;
      3'd2:    corner = 2'd2;
      3'd3:    corner = 2'd2;
      3'd4:    corner = 2'd1;
      3'd5:    corner = 2'd3;
      default: corner = 2'd0;
    endcase
  end

  assign rx   = corner[0] ? 21'(q_head.dw) : -21'(q_head.dw);
  assign ry   = corner[1] ? 21'(q_head.dh) : -21'(q_head.dh);
  assign su_d = corner[0] ? q_head.u1 : q_head.u0;
  assign sv_d = corner[1] ? q_head.v1 : q_head.v0;

  // bias terms move the rounded, clamped quotient to an unsigned range
  assign kx = $signed((40'(cfg.vp_w) << 19) + (40'(cfg.vp_w) << 4));
  assign ky = $signed((40'(cfg.vp_h) << 19) - (40'(cfg.vp_h) << 4));
  assign ku = $signed((40'(cfg.tex_w) << 18) + 40'(cfg.tex_w));
  assign kv = $signed((40'(cfg.tex_h) << 18) + 40'(cfg.tex_h));

  assign den_x = sqvs_pkg::DIV_D_W'(cfg.vp_w) << 5;
  assign den_y = sqvs_pkg::DIV_D_W'(cfg.vp_h) << 5;
  assign den_u = sqvs_pkg::DIV_D_W'(cfg.tex_w) << 1;
  assign den_v = sqvs_pkg::DIV_D_W'(cfg.tex_h) << 1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt           <= '0;
      a_v           <= 1'b0;
      b_v           <= 1'b0;
      c_v           <= 1'b0;
      m_axis_tvalid <= 1'b0;
      for (int i = 0; i < sqvs_pkg::DIV_LAT; i++) sb_v[i] <= 1'b0;
    end else if (adv) begin
      if (issue) cnt <= (cnt == sqvs_pkg::LAST_VTX) ? '0 : cnt + 1'b1;
      a_v     <= q_valid;
      b_v     <= a_v;
      c_v     <= b_v;
      sb_v[0] <= c_v;
      for (int i = 1; i < sqvs_pkg::DIV_LAT; i++) sb_v[i] <= sb_v[i-1];
      m_axis_tvalid <= sb_v[sqvs_pkg::DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_pcx  <= q_head.cos_v * rx;
      a_psy  <= q_head.sin_v * ry;
      a_psx  <= q_head.sin_v * rx;
      a_pcy  <= q_head.cos_v * ry;
      a_cx5  <= q_head.cx5;
      a_cy5  <= q_head.cy5;
      a_su   <= su_d;
      a_sv   <= sv_d;
      a_col  <= q_head.color;
      a_last <= cnt == sqvs_pkg::LAST_VTX;

      b_x    <= (39'(a_cx5) <<< 14) + 39'(a_pcx) - 39'(a_psy);
      b_y    <= (39'(a_cy5) <<< 14) + 39'(a_psx) + 39'(a_pcy);
      b_su   <= a_su;
      b_sv   <= a_sv;
      b_col  <= a_col;
      b_last <= a_last;

      c_nx   <= (40'(b_x) <<< 1) + kx;
      c_ny   <= (40'(b_y) <<< 1) + ky;
      c_nu   <= (40'(b_su) <<< 11) + ku;
      c_nv   <= (40'(b_sv) <<< 11) + kv;
      c_col  <= b_col;
      c_last <= b_last;

      sb_col[0]  <= c_col;
      sb_last[0] <= c_last;
      for (int i = 1; i < sqvs_pkg::DIV_LAT; i++) begin
        sb_col[i]  <= sb_col[i-1];
        sb_last[i] <= sb_last[i-1];
      end

      m_axis_tdata <= {4'b0000, qv[17] ^ 1'b1, qv[16:0], qu[17] ^ 1'b1, qu[16:0],
                       sb_col[sqvs_pkg::DIV_LAT-1], vy, vx};
      m_axis_tlast <= sb_last[sqvs_pkg::DIV_LAT-1];
    end
  end

  sqvs_div u_div_x (.clk(clk), .en(adv), .num(c_nx), .den(den_x), .quo(qx));
  sqvs_div u_div_y (.clk(clk), .en(adv), .num(c_ny), .den(den_y), .quo(qy));
  sqvs_div u_div_u (.clk(clk), .en(adv), .num(c_nu), .den(den_u), .quo(qu));
  sqvs_div u_div_v (.clk(clk), .en(adv), .num(c_nv), .den(den_v), .quo(qv));

  // ndc quotients saturate to 16 bits, then remove the bias
  assign x16 = (qx[17:16] != 2'b00) ? 16'hFFFF : qx[15:0];
  assign y16 = (qy[17:16] != 2'b00) ? 16'hFFFF : qy[15:0];
  assign vx  = {~x16[15], x16[14:0]};
  assign vy  = 16'h7FFF - y16;

  // mid-quad the command must still sit at the queue head
  a_head_kept: assert property (@(posedge clk) disable iff (rst)
    (cnt != '0) |-> q_valid)
    else $error("command left queue before its sixth vertex");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (cnt == '0))
    else $error("vertex counter not restarted after pop");

endmodule

// ===== tb/sv/tb.sv =====
// tb: self-checking bench for sprite_quad_vertex_setup. A queue-fed driver,
// a monitor checking six predicted vertices per command and config writes
// between phases. Depends on sqvs_pkg and the block's rtl.
module tb;

  localparam int TAB_N      = 1024;
  localparam int DRAIN_WAIT = 60;
  localparam int STALL_MAX  = 3000;

  typedef enum logic [7:0] {
    REG_VP_W  = sqvs_pkg::REG_VIEWPORT_W,
    REG_VP_H  = sqvs_pkg::REG_VIEWPORT_H,
    REG_TEX_W = sqvs_pkg::REG_TEXTURE_W,
    REG_TEX_H = sqvs_pkg::REG_TEXTURE_H,
    REG_BAD   = 8'd7
  } reg_idx_e;

  typedef struct {
    logic signed [19:0] dx, dy, dw, dh;
    logic [15:0]        ang;
    logic [31:0]        col;
    logic signed [19:0] sx, sy, sw, sh;
    logic               whole;
  } sprite_t;

  typedef struct {
    logic [15:0] px, py;
    logic [31:0] col;
    logic [17:0] u, v;
    logic        last;
  } vertex_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [sqvs_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                            s_axis_tuser = 1'b0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [sqvs_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                            m_axis_tlast;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [7:0]                      cfg_index = '0;
  logic [sqvs_pkg::REG_W-1:0]      cfg_data = '0;

  sprite_quad_vertex_setup DUT (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  longint    cos_lut[TAB_N];
  longint    sin_lut[TAB_N];
  logic [13:0] vp_w = 14'd1280, vp_h = 14'd720, tex_w = 14'd256, tex_h = 14'd256;
  sprite_t   pending_cmds[$];
  vertex_t   expected_verts[$];
  int        send_idle = 0, recv_stall = 0;
  int        errors = 0, cmds_taken = 0, verts_seen = 0, sat_hits = 0;
  int        quiet_cycles = 0;

  function automatic longint sine_q14(logic [31:0] ph);
    longint unsigned r, x, x2, term;
    longint          sum, q;
    r = ph[29:0];
    if (ph[30]) r = 64'h4000_0000 - r;
    x = (r * 64'd1686629713) >> 30;
    x2 = (x * x) >> 30;
    term = x;
    sum = longint'(x);
    for (int k = 1; k <= 8; k++) begin
      term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    q = (sum + 32768) >>> 16;
    if (q > 16384) q = 16384;
    return ph[31] ? -q : q;
  endfunction

  // nearest, ties toward plus infinity
  function automatic longint div_nearest(longint n, longint d);
    longint num, den, q;
    num = 2 * n + d;
    den = 2 * d;
    q = num / den;
    if (num % den != 0 && num < 0) q--;
    return q;
  endfunction

  function automatic longint sat(longint val, longint lo, longint hi);
    if (val < lo || val > hi) sat_hits++;
    return val < lo ? lo : (val > hi ? hi : val);
  endfunction

  function automatic longint at_least_one(logic [13:0] r);
    return r == 0 ? 1 : longint'(r);
  endfunction

  function automatic void predict_quad(sprite_t c);
    longint  w, h, tw, th, cx5, cy5, cs, sn, sw, sh, rx, ry, bx, by;
    longint  px[4], py[4], uu[2], vv[2];
    int      order[6] = '{0, 1, 2, 2, 1, 3};
    int      cn, idx;
    vertex_t vt;
    w = at_least_one(vp_w);
    h = at_least_one(vp_h);
    tw = at_least_one(tex_w);
    th = at_least_one(tex_h);
    cx5 = 2 * longint'(c.dx) + longint'(c.dw);
    cy5 = 2 * longint'(c.dy) + longint'(c.dh);
    idx = c.ang >> 6;
    cs = cos_lut[idx];
    sn = sin_lut[idx];
    sw = c.whole ? tw * 16 : longint'(c.sw);
    sh = c.whole ? th * 16 : longint'(c.sh);
    for (int k = 0; k < 4; k++) begin
      rx = (k & 1) ? longint'(c.dw) : -longint'(c.dw);
      ry = (k & 2) ? longint'(c.dh) : -longint'(c.dh);
      bx = cx5 * 16384 + cs * rx - sn * ry;
      by = cy5 * 16384 + sn * rx + cs * ry;
      px[k] = sat(div_nearest(bx, 16 * w) - 16384, -32768, 32767);
      py[k] = sat(16384 - div_nearest(by, 16 * h), -32768, 32767);
    end
    uu[0] = sat(div_nearest(longint'(c.sx) * 1024, tw), -131072, 131071);
    uu[1] = sat(div_nearest((longint'(c.sx) + sw) * 1024, tw), -131072, 131071);
    vv[0] = sat(div_nearest(longint'(c.sy) * 1024, th), -131072, 131071);
    vv[1] = sat(div_nearest((longint'(c.sy) + sh) * 1024, th), -131072, 131071);
    for (int k = 0; k < 6; k++) begin
      cn = order[k];
      vt.px = px[cn][15:0];
      vt.py = py[cn][15:0];
      vt.col = c.col;
      vt.u = uu[cn & 1][17:0];
      vt.v = vv[(cn >> 1) & 1][17:0];
      vt.last = (k == 5);
      expected_verts.push_back(vt);
    end
  endfunction

  // driver: holds an item until taken, predicts on acceptance
  always @(posedge clk) begin
    sprite_t c;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_quad(pending_cmds.pop_front());
        cmds_taken++;
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // keep presenting the same item
      end else if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle) begin
        c = pending_cmds[0];
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {c.sh, c.sw, c.sy, c.sx, c.col, c.ang, c.dh, c.dw, c.dy, c.dx};
        s_axis_tuser <= c.whole;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor: field-by-field compare against the oldest expected vertex
  always @(posedge clk) begin
    vertex_t e;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        verts_seen++;
        if (expected_verts.size() == 0) begin
          errors++;
          $display("%0t: unexpected vertex %h last %b", $time, m_axis_tdata, m_axis_tlast);
        end else begin
          e = expected_verts.pop_front();
          if (m_axis_tdata[15:0] !== e.px || m_axis_tdata[31:16] !== e.py ||
              m_axis_tdata[63:32] !== e.col || m_axis_tdata[81:64] !== e.u ||
              m_axis_tdata[99:82] !== e.v || m_axis_tlast !== e.last) begin
            errors++;
            $display("%0t: vertex mismatch exp x=%h y=%h c=%h u=%h v=%h l=%b", $time,
                     e.px, e.py, e.col, e.u, e.v, e.last);
            $display("%0t:                 act x=%h y=%h c=%h u=%h v=%h l=%b", $time,
                     m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[63:32],
                     m_axis_tdata[81:64], m_axis_tdata[99:82], m_axis_tlast);
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_MAX) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [13:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_VP_W:  vp_w = val;
      REG_VP_H:  vp_h = val;
      REG_TEX_W: tex_w = val;
      REG_TEX_H: tex_h = val;
      default: ;
    endcase
  endtask

  task automatic set_sizes(logic [13:0] w, logic [13:0] h, logic [13:0] tw, logic [13:0] th);
    write_reg(REG_VP_W, w);
    write_reg(REG_VP_H, h);
    write_reg(REG_TEX_W, tw);
    write_reg(REG_TEX_H, th);
    write_reg(REG_BAD, 14'd3);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_cmds.size() > 0 || expected_verts.size() > 0 || s_axis_tvalid)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic logic signed [19:0] pick20();
    case ($urandom_range(7))
      0: return 20'sh80000;
      1: return 20'sh7FFFF;
      2: return 20'sd0;
      3, 4: return 20'($signed(12'($urandom)));
      default: return 20'($urandom);
    endcase
  endfunction

  function automatic sprite_t rand_sprite();
    sprite_t c;
    c.dx = pick20(); c.dy = pick20(); c.dw = pick20(); c.dh = pick20();
    c.sx = pick20(); c.sy = pick20(); c.sw = pick20(); c.sh = pick20();
    c.ang = 16'($urandom);
    c.col = $urandom;
    c.whole = 1'($urandom_range(1));
    return c;
  endfunction

  function automatic sprite_t simple_sprite(int x, int y, int w, int h, logic [15:0] a,
                                            logic wt);
    sprite_t c;
    c.dx = 20'(x); c.dy = 20'(y); c.dw = 20'(w); c.dh = 20'(h); c.ang = a; c.whole = wt;
    c.col = $urandom;
    c.sx = 20'(16 * 8); c.sy = 20'(16 * 4); c.sw = 20'(16 * 32); c.sh = 20'(-16 * 16);
    return c;
  endfunction

  initial begin
    logic [15:0] angles[7] = '{16'd0, 16'd63, 16'd64, 16'd16384, 16'd32768, 16'd49152,
                               16'd65535};
    logic [13:0] cfgs[6][4] = '{
      '{14'd1280, 14'd720, 14'd256, 14'd256},
      '{14'd1, 14'd1, 14'd1, 14'd1},
      '{14'd8192, 14'd8192, 14'd8192, 14'd8192},
      '{14'd0, 14'd16383, 14'd0, 14'd16383},
      '{14'd640, 14'd480, 14'd64, 14'd1024},
      '{14'd1920, 14'd1080, 14'd4096, 14'd32}};
    int idle_mix[6][2] = '{'{0, 0}, '{59, 0}, '{0, 59}, '{37, 37}, '{0, 0}, '{37, 37}};
    sprite_t c;

    for (int i = 0; i < TAB_N; i++) begin
      sin_lut[i] = sine_q14(32'(i) << 22);
      cos_lut[i] = sine_q14((32'(i) << 22) + 32'h4000_0000);
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: angles, whole texture, mirrored and extreme rectangles
    foreach (angles[i])
      pending_cmds.push_back(simple_sprite(16 * 100, 16 * 50, 16 * 64, 16 * 32, angles[i],
                                           1'(i % 2)));
    pending_cmds.push_back(simple_sprite(16 * 300, 16 * 200, -16 * 40, -16 * 20, 16'd8192,
                                         1'b0));
    pending_cmds.push_back(simple_sprite(0, 0, 0, 0, 16'd0, 1'b0));
    c.dx = 20'sh80000; c.dy = 20'sh80000; c.dw = 20'sh80000; c.dh = 20'sh80000;
    c.sx = 20'sh80000; c.sy = 20'sh80000; c.sw = 20'sh80000; c.sh = 20'sh80000;
    c.ang = 16'hFFFF; c.col = 32'h0000_0000; c.whole = 1'b0;
    pending_cmds.push_back(c);
    c.dx = 20'sh7FFFF; c.dy = 20'sh7FFFF; c.dw = 20'sh7FFFF; c.dh = 20'sh7FFFF;
    c.sx = 20'sh7FFFF; c.sy = 20'sh7FFFF; c.sw = 20'sh7FFFF; c.sh = 20'sh7FFFF;
    c.ang = 16'h0000; c.col = 32'hFFFF_FFFF; c.whole = 1'b1;
    pending_cmds.push_back(c);
    c.whole = 1'b0;
    pending_cmds.push_back(c);
    drain();

    for (int p = 0; p < 6; p++) begin
      set_sizes(cfgs[p][0], cfgs[p][1], cfgs[p][2], cfgs[p][3]);
      send_idle = idle_mix[p][0];
      recv_stall = idle_mix[p][1];
      for (int n = 0; n < 72; n++) pending_cmds.push_back(rand_sprite());
      drain();
    end

    $display("covered %0d sprite commands, %0d vertices, %0d saturated coordinates",
             cmds_taken, verts_seen, sat_hits);
    $display("over six size settings and four idling mixes, %0d errors", errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
